### rtl/three_motor_pwm_deadband_assert.svh
// Assertion macros shared by the motor PWM block.
`ifndef THREE_MOTOR_PWM_DEADBAND_ASSERT_SVH
`define THREE_MOTOR_PWM_DEADBAND_ASSERT_SVH

// Check cons in the same cycle as ante, outside reset.
`define TMPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante, outside reset.
`define TMPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/tmpd_pkg.sv
// Types, codes and reset constants for the three-motor PWM block.
package tmpd_pkg;

  localparam int SampleW = 8;
  localparam int StepW   = 7;
  localparam int PortW   = 6;
  localparam int NumMot  = 3;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 8;

  localparam logic [SampleW-1:0] RevLimitRst = 8'd120;
  localparam logic [SampleW-1:0] FwdLimitRst = 8'd135;
  localparam logic [StepW-1:0]   PeriodRst   = 7'd100;
  localparam logic [7:0]         RevBase     = 8'd80;
  localparam logic [7:0]         FwdBase     = 8'd20;

  // Item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_REV_LIMIT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FWD_LIMIT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PERIOD    = 2'd2;

  typedef struct packed {
    logic               kind;
    logic [SampleW-1:0] sample_a;
    logic [SampleW-1:0] sample_b;
    logic [SampleW-1:0] sample_c;
  } in_item_t;

  typedef struct packed {
    logic [PortW-1:0] port_value;
    logic [StepW-1:0] step_index;
  } out_item_t;

  typedef struct packed {
    logic [SampleW-1:0] rev_limit;
    logic [SampleW-1:0] fwd_limit;
    logic [StepW-1:0]   period;
  } cfg_regs_t;

  // A period of zero behaves as one.
  function automatic logic [StepW-1:0] eff_period(input logic [StepW-1:0] p);
    eff_period = (p == '0) ? StepW'(1) : p;
  endfunction

endpackage

### rtl/tmpd_cfg.sv
// Configuration register file: limits and PWM period.
module tmpd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tmpd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tmpd_pkg::CfgDataW-1:0]  cfg_data,
  output tmpd_pkg::cfg_regs_t            regs
);
  import tmpd_pkg::*;

  cfg_regs_t regs_r;

  // Always take writes; unknown indexes are dropped
  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.rev_limit <= RevLimitRst;
      regs_r.fwd_limit <= FwdLimitRst;
      regs_r.period    <= PeriodRst;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_REV_LIMIT: regs_r.rev_limit <= cfg_data;
        CFG_FWD_LIMIT: regs_r.fwd_limit <= cfg_data;
        CFG_PERIOD:    regs_r.period    <= cfg_data[StepW-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/tmpd_duty.sv
// Sample to duty and direction mapping for one motor.
module tmpd_duty (
  input  logic [tmpd_pkg::SampleW-1:0] sample,
  input  tmpd_pkg::cfg_regs_t          regs,
  output logic [tmpd_pkg::StepW-1:0]   duty,
  output logic                         fwd
);
  import tmpd_pkg::*;

  logic [SampleW:0]   half_up;   // ceil(v/2), up to 128
  logic [SampleW-1:0] fwd_diff;
  logic [7:0]         raw;
  logic [StepW-1:0]   per;

  always_comb begin
    per      = eff_period(regs.period);
    half_up  = ({1'b0, sample} + 9'd1) >> 1;
    fwd_diff = sample - regs.fwd_limit;
    fwd      = 1'b0;
    // Reverse test wins where the limits overlap
    if (sample < regs.rev_limit) begin
      raw = (half_up > {1'b0, RevBase}) ? 8'd0 : (RevBase - half_up[7:0]);
    end else if (sample > regs.fwd_limit) begin
      raw = FwdBase + {1'b0, fwd_diff[SampleW-1:1]};
      fwd = 1'b1;
    end else begin
      raw = 8'd0;
    end
    // Saturate to the period
    duty = (raw > {1'b0, per}) ? per : raw[StepW-1:0];
  end

endmodule

### rtl/three_motor_pwm_deadband.sv
// Ticks pass the input register, then the result register; loads stop at motor state.
// Throughput: one item per cycle unless a held tick waits on a result not yet taken;
// a load updates duty and direction, a tick emits one result. Mapping is combinational.
// Reset: synchronous active-low; limits 120/135, period 100, duty, direction and step cleared.
// Configuration writes are taken every cycle and must arrive while the block is idle.
module three_motor_pwm_deadband (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tmpd_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tmpd_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tmpd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tmpd_pkg::CfgDataW-1:0] cfg_data
);
  import tmpd_pkg::*;
  `include "three_motor_pwm_deadband_assert.svh"

  cfg_regs_t        regs;
  in_item_t         inq_r;
  logic             inq_valid_r;
  out_item_t        out_r;
  logic             out_valid_r;
  logic [StepW-1:0] duty_r [NumMot];
  logic [NumMot-1:0] fwd_bits_r;
  logic [StepW-1:0] step_r;
  logic [StepW-1:0] step_nxt;
  logic [StepW-1:0] duty_new [NumMot];
  logic [NumMot-1:0] fwd_new;
  logic [PortW-1:0] port_nxt;
  logic [StepW-1:0] per;
  logic             is_load;
  logic             adv;

  tmpd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  tmpd_duty u_duty_a (.sample(inq_r.sample_a), .regs(regs), .duty(duty_new[0]), .fwd(fwd_new[0]));
  tmpd_duty u_duty_b (.sample(inq_r.sample_b), .regs(regs), .duty(duty_new[1]), .fwd(fwd_new[1]));
  tmpd_duty u_duty_c (.sample(inq_r.sample_c), .regs(regs), .duty(duty_new[2]), .fwd(fwd_new[2]));

  // Retire the held item when a load, or when the result slot frees up
  assign is_load  = (inq_r.kind == KIND_LOAD);
  assign adv      = inq_valid_r && (is_load || !out_valid_r || out_ready);
  assign in_ready = !inq_valid_r || adv;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Build the six-bit port value for the current step and the wrapped next step
  always_comb begin
    per = eff_period(regs.period);
    for (int ch = 0; ch < NumMot; ch++) begin
      port_nxt[2*ch]   = fwd_bits_r[ch];
      port_nxt[2*ch+1] = (step_r < duty_r[ch]);
    end
    if (({1'b0, step_r} + 8'd1) >= {1'b0, per}) begin
      step_nxt = '0;
    end else begin
      step_nxt = step_r + StepW'(1);
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_ready) begin
      inq_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      inq_r <= in_data;
    end
  end

  // Motor state: loads latch duty and direction and restart the step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int ch = 0; ch < NumMot; ch++) begin
        duty_r[ch] <= '0;
      end
      fwd_bits_r <= '0;
      step_r     <= '0;
    end else if (adv) begin
      if (is_load) begin
        for (int ch = 0; ch < NumMot; ch++) begin
          duty_r[ch] <= duty_new[ch];
        end
        fwd_bits_r <= fwd_new;
        step_r     <= '0;
      end else begin
        step_r <= step_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && !is_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (adv && !is_load) begin
      out_r.port_value <= port_nxt;
      out_r.step_index <= step_r;
    end
  end

  `TMPD_ASSERT_NEXT(a_load_restarts_step, adv && is_load, step_r == '0, "load did not clear step")
  `TMPD_ASSERT_NEXT(a_tick_gives_result, adv && !is_load, out_valid_r, "tick lost its result")
  `TMPD_ASSERT_NEXT(a_no_repeat, out_valid_r && out_ready && !(adv && !is_load), !out_valid_r,
                    "result repeated after transfer")
  `TMPD_ASSERT_NOW(a_stall_only_when_full, !in_ready, inq_valid_r && out_valid_r && !out_ready,
                   "input stalled without cause")

endmodule
